// ===== rtl/lps_pkg.sv =====
// Shared constants, operation codes and control structs for the list store.
`timescale 1ns / 1ps
package lps_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int LEN_W     = 5;
  localparam int CAP_W     = 5;
  localparam int KIND_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic idle;
    logic judge;
    logic start;
    logic shift;
    logic flush;
    logic put;
    logic fetch;
    logic finish;
  } lps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              req_valid;
    logic              ok_now;
    logic              more;
    logic [KIND_W-1:0] kind;
    logic              rsp_busy;
  } lps_stat_t;

endpackage

// ===== rtl/lps_if.sv =====
// Request, response and capacity-write channel interfaces.
`timescale 1ns / 1ps
interface lps_req_if import lps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface lps_rsp_if import lps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic [LEN_W-1:0]         length;
  logic                     full_res;

  modport source (output valid, ok, read_value, length, full_res, input ready);
  modport sink   (input valid, ok, read_value, length, full_res, output ready);
endinterface

interface lps_cfg_if import lps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/lps_ctrl.sv =====
// Sequencer for the list store: steps each operation through the datapath.
`timescale 1ns / 1ps
module lps_ctrl import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lps_stat_t stat,
  output lps_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SHIFT,
    ST_FLUSH,
    ST_PUT,
    ST_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.idle = 1'b1;
      ST_CHECK: begin
        cmd.judge = 1'b1;
        if (stat.ok_now) begin
          if (stat.kind == KIND_READ) begin
            cmd.fetch = 1'b1;
          end else begin
            cmd.start = 1'b1;
          end
        end
      end
      ST_SHIFT: cmd.shift  = stat.more;
      ST_FLUSH: cmd.flush  = 1'b1;
      ST_PUT:   cmd.put    = 1'b1;
      ST_DONE:  cmd.finish = !stat.rsp_busy;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (stat.req_valid) state <= ST_CHECK;
        end
        ST_CHECK: begin
          // rejected ops and reads go straight to the result
          if (stat.ok_now && (stat.kind == KIND_INSERT || stat.kind == KIND_REMOVE)) begin
            state <= ST_SHIFT;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SHIFT: begin
          if (!stat.more) state <= ST_FLUSH;
        end
        ST_FLUSH: state <= ST_PUT;
        ST_PUT:   state <= ST_DONE;
        ST_DONE: begin
          if (!stat.rsp_busy) state <= ST_IDLE;
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lps_datapath.sv =====
// Entry memory, count, capacity register, shift pointer and result register.
`timescale 1ns / 1ps
module lps_datapath import lps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  lps_req_if.sink          req,
  lps_rsp_if.source        rsp,
  lps_cfg_if.sink          cfg,
  input  lps_cmd_t         cmd,
  output lps_stat_t        stat
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic [CNT_W-1:0]  count;
  logic [CAP_W-1:0]  cap;
  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic              ok_q;
  logic [AW-1:0]     ptr;
  logic              pend;
  logic [AW-1:0]     pend_addr;

  logic              rsp_valid;
  logic              rsp_ok;
  logic [DATA_W-1:0] rsp_rv;
  logic [LEN_W-1:0]  rsp_len;
  logic              rsp_full;

  logic [CMP_W-1:0]  cnt_ext, pos_ext, ptr_ext, cap_ext, depth_ext, cap_eff;
  logic              ok_now, more, up, take;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  // nothing is taken while reset is held
  assign req.ready = cmd.idle & ~rst;
  assign take      = req.valid & req.ready;
  assign cfg.ready = ~rst;

  assign cnt_ext   = CMP_W'(count);
  assign pos_ext   = CMP_W'(pos_q);
  assign ptr_ext   = CMP_W'(ptr);
  assign cap_ext   = CMP_W'(cap);
  assign depth_ext = CMP_W'(DEPTH);
  assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign up        = (kind_q == KIND_INSERT);

  always_comb begin
    case (kind_q)
      KIND_INSERT: ok_now = (cnt_ext < cap_eff) && (pos_ext <= cnt_ext) &&
                            (cnt_ext < depth_ext);
      KIND_REMOVE: ok_now = (pos_ext < cnt_ext);
      KIND_READ:   ok_now = (pos_ext < cnt_ext);
      default:     ok_now = 1'b0;
    endcase
  end

  // insert walks down toward pos, remove walks up toward the tail
  assign more = up ? (ptr_ext > pos_ext) : ((ptr_ext + CMP_W'(1)) < cnt_ext);

  assign stat.req_valid = req.valid;
  assign stat.ok_now    = ok_now;
  assign stat.more      = more;
  assign stat.kind      = kind_q;
  assign stat.rsp_busy  = rsp_valid & ~rsp.ready;

  assign rd_en   = cmd.shift | cmd.fetch;
  assign rd_addr = cmd.fetch ? pos_ext[AW-1:0] : (up ? ptr - AW'(1) : ptr + AW'(1));
  assign wr_en   = ((cmd.shift | cmd.flush) & pend) | (cmd.put & up);
  assign wr_addr = cmd.put ? ptr : pend_addr;
  assign wr_data = cmd.put ? val_q : rd_q;

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_q <= req.kind;
      pos_q  <= req.position;
      val_q  <= req.value;
    end
    if (cmd.judge) ok_q <= ok_now;
    if (cmd.start) begin
      ptr <= up ? count[AW-1:0] : pos_ext[AW-1:0];
    end else if (cmd.shift) begin
      ptr       <= up ? ptr - AW'(1) : ptr + AW'(1);
      pend_addr <= ptr;
    end
    if (cmd.finish) begin
      rsp_ok   <= ok_q;
      rsp_rv   <= (ok_q && kind_q == KIND_READ) ? rd_q : '0;
      rsp_len  <= cnt_ext[LEN_W-1:0];
      rsp_full <= (cnt_ext >= cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap       <= CAP_RESET;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) cap <= cfg.data;
      if (cmd.start || cmd.flush) begin
        pend <= 1'b0;
      end else if (cmd.shift) begin
        pend <= 1'b1;
      end
      if (cmd.put) count <= up ? count + CNT_W'(1) : count - CNT_W'(1);
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.ok         = rsp_ok;
  assign rsp.read_value = rsp_rv;
  assign rsp.length     = rsp_len;
  assign rsp.full_res   = rsp_full;

endmodule

// ===== rtl/positional_list_store.sv =====
// Positional list store: ordered list with insert, remove and read at an index.
`timescale 1ns / 1ps
// Channels:
//   req  - one beat per operation: kind (insert/remove/read), position, value.
//   rsp  - one beat per operation: ok, read_value, length, full_res.
//   cfg  - capacity write; ready whenever out of reset; user must write it only while idle, unchecked by the block.
// Operation flow (p = position):
//   read or rejected op : checked, then straight to the response.
//   insert or remove    : checked, shift pass between p and the tail, flush, then put.
//   With no rsp stall, the next request is taken at the edge of the previous response beat.
//   The entries live in a single-port-write, registered-read memory, so an
//   insert or remove moves one entry per cycle through the read/write pair;
//   that shift pass sets the cost of an operation.
// One operation is in flight at a time; req.ready is high only while idle.
// The response sits in an output register: if rsp stalls, the next request
// is still taken and worked, and its result waits until the register frees.
// Reset: list empty, capacity 16, no response pending. Memory contents are
// not cleared; entries are only read after they have been written.
module positional_list_store import lps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lps_req_if.sink   req,
  lps_rsp_if.source rsp,
  lps_cfg_if.sink   cfg
);

  lps_cmd_t  cmd;
  lps_stat_t stat;

  // sequencer: one state per phase of an operation
  lps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // storage, pointer arithmetic and the result register
  lps_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
